[sv/hnfe_pkg.sv]
// Shared types, codes and helpers for the HDLC NRZI frame bit encoder.
// Holds the microcode table and the CRC step. No dependencies.
package hnfe_pkg;

    // Command codes carried on s_tuser
    typedef enum logic [1:0] {
        CMD_FLAG = 2'd0,
        CMD_DATA = 2'd1,
        CMD_FCS  = 2'd2,
        CMD_RSVD = 2'd3
    } cmd_t;

    // Sequencer step addresses
    typedef logic [1:0] step_t;
    localparam step_t STEP_FETCH = 2'd0;
    localparam step_t STEP_BIT   = 2'd1;
    localparam step_t STEP_STUFF = 2'd2;
    localparam step_t STEP_SPARE = 2'd3;

    localparam logic [15:0] CRC_POLY  = 16'h8408;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [2:0]  RUN_STUFF = 3'd4;   // run count before the fifth one
    localparam logic [2:0]  BIT_LAST  = 3'd7;

    // One control word per step
    typedef struct packed {
        logic  op_accept;   // take an input word and load the datapath
        logic  op_bit;      // send the next shift register bit
        logic  op_stuff;    // send a stuffing zero
        step_t jmp_stuff;   // target when a stuffing zero is due
        step_t jmp_done;    // target when the item is finished
        step_t jmp_next;    // target otherwise
    } ctrl_word_t;

    // Datapath conditions back to the sequencer
    typedef struct packed {
        logic go;           // the step completes this cycle
        logic stuff_need;   // five ones seen, insert a zero
        logic item_end;     // last bit period of the item, or an ignored command
    } dp_status_t;

    // Microcode program
    function automatic ctrl_word_t ucode_rom(input step_t pc);
        ctrl_word_t w;
        case (pc)
            STEP_FETCH: w = '{1'b1, 1'b0, 1'b0, STEP_FETCH, STEP_FETCH, STEP_BIT};
            STEP_BIT:   w = '{1'b0, 1'b1, 1'b0, STEP_STUFF, STEP_FETCH, STEP_BIT};
            STEP_STUFF: w = '{1'b0, 1'b0, 1'b1, STEP_FETCH, STEP_FETCH, STEP_BIT};
            default:    w = '{1'b0, 1'b0, 1'b0, STEP_FETCH, STEP_FETCH, STEP_FETCH};
        endcase
        return w;
    endfunction

    // Reflected CRC-16-CCITT, one bit
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic b);
        logic fb;
        fb = crc[0] ^ b;
        return fb ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
    endfunction

endpackage

[sv/hnfe_sequencer.sv]
// Microcode sequencer: step counter, control word lookup and jumps.
// Depends on hnfe_pkg for the program table and control types.
module hnfe_sequencer (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  hnfe_pkg::dp_status_t   status,
    output hnfe_pkg::ctrl_word_t   ctrl
);
    import hnfe_pkg::*;

    step_t pc_reg;
    step_t pc_next;

    // Look up the control word of the current step
    assign ctrl = ucode_rom(pc_reg);

    // Pick the jump target once the step completes
    always_comb begin
        pc_next = pc_reg;
        if (status.go) begin
            if (status.stuff_need) begin
                pc_next = ctrl.jmp_stuff;
            end else if (status.item_end) begin
                pc_next = ctrl.jmp_done;
            end else begin
                pc_next = ctrl.jmp_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_FETCH;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

[sv/hnfe_datapath.sv]
// Datapath: byte shifter, CRC, ones run count, NRZI line state, output register.
// Driven by control words from hnfe_sequencer; depends on hnfe_pkg.
module hnfe_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  hnfe_pkg::ctrl_word_t   ctrl,
    output hnfe_pkg::dp_status_t   status,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);
    import hnfe_pkg::*;

    logic [7:0]  shift_reg,  shift_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic [15:0] crc_reg,    crc_next;
    logic [2:0]  run_reg,    run_next;
    logic        tone_reg,   tone_next;
    logic        hi_pend_reg, hi_pend_next;
    cmd_t        mode_reg,   mode_next;
    logic        ov_reg,     ov_next;
    logic        otone_reg,  otone_next;
    logic        ostuff_reg, ostuff_next;
    logic        olast_reg,  olast_next;

    logic        out_free;
    logic        cur_bit;
    logic [2:0]  run_in;
    logic        byte_end;
    logic        go;
    logic        stuff_need;
    logic        item_end;
    cmd_t        cmd_in;

    assign out_free = !ov_reg || m_tready;
    assign cur_bit  = shift_reg[0];
    assign run_in   = (mode_reg == CMD_FLAG) ? 3'd0 : run_reg;
    assign cmd_in   = cmd_t'(s_tuser);
    assign s_tready = ctrl.op_accept;

    // Step completion and branch conditions
    always_comb begin
        go         = 1'b1;
        stuff_need = 1'b0;
        byte_end   = 1'b0;
        item_end   = 1'b0;
        if (ctrl.op_accept) begin
            go       = s_tvalid;
            item_end = (cmd_in == CMD_RSVD);
        end else if (ctrl.op_bit) begin
            go         = out_free;
            stuff_need = cur_bit && (run_in == RUN_STUFF);
            byte_end   = (bit_cnt_reg == BIT_LAST) && !stuff_need;
            item_end   = byte_end && !hi_pend_reg;
        end else if (ctrl.op_stuff) begin
            go       = out_free;
            byte_end = (bit_cnt_reg == 3'd0);
            item_end = byte_end && !hi_pend_reg;
        end
    end

    assign status = '{go, stuff_need, item_end};

    // Next state of the datapath
    always_comb begin
        shift_next   = shift_reg;
        bit_cnt_next = bit_cnt_reg;
        crc_next     = crc_reg;
        run_next     = run_reg;
        tone_next    = tone_reg;
        hi_pend_next = hi_pend_reg;
        mode_next    = mode_reg;
        ov_next      = ov_reg && !m_tready;
        otone_next   = otone_reg;
        ostuff_next  = ostuff_reg;
        olast_next   = olast_reg;

        if (go && ctrl.op_accept) begin
            // load the byte for a flag, data or FCS command
            bit_cnt_next = 3'd0;
            case (cmd_in)
                CMD_FLAG: begin
                    shift_next   = FLAG_BYTE;
                    crc_next     = CRC_INIT;
                    hi_pend_next = 1'b0;
                    mode_next    = CMD_FLAG;
                end
                CMD_DATA: begin
                    shift_next   = s_tdata;
                    hi_pend_next = 1'b0;
                    mode_next    = CMD_DATA;
                end
                CMD_FCS: begin
                    shift_next   = ~crc_reg[7:0];
                    hi_pend_next = 1'b1;
                    mode_next    = CMD_FCS;
                end
                default: begin
                    bit_cnt_next = bit_cnt_reg;
                end
            endcase
        end else if (go && ctrl.op_bit) begin
            // send one bit, NRZI: zero toggles the line
            if (mode_reg == CMD_DATA) begin
                crc_next = crc_step(crc_reg, cur_bit);
            end
            tone_next    = cur_bit ? tone_reg : ~tone_reg;
            run_next     = cur_bit ? (run_in + 3'd1) : 3'd0;
            shift_next   = {1'b0, shift_reg[7:1]};
            bit_cnt_next = bit_cnt_reg + 3'd1;
            ov_next      = 1'b1;
            otone_next   = tone_next;
            ostuff_next  = 1'b0;
            olast_next   = item_end;
        end else if (go && ctrl.op_stuff) begin
            // insert a stuffing zero
            tone_next   = ~tone_reg;
            run_next    = 3'd0;
            ov_next     = 1'b1;
            otone_next  = tone_next;
            ostuff_next = 1'b1;
            olast_next  = item_end;
        end

        // advance to the FCS high byte
        if (go && byte_end && hi_pend_reg) begin
            shift_next   = ~crc_reg[15:8];
            hi_pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg     <= CRC_INIT;
            run_reg     <= 3'd0;
            tone_reg    <= 1'b0;
            hi_pend_reg <= 1'b0;
            mode_reg    <= CMD_FLAG;
            bit_cnt_reg <= 3'd0;
            ov_reg      <= 1'b0;
        end else begin
            crc_reg     <= crc_next;
            run_reg     <= run_next;
            tone_reg    <= tone_next;
            hi_pend_reg <= hi_pend_next;
            mode_reg    <= mode_next;
            bit_cnt_reg <= bit_cnt_next;
            ov_reg      <= ov_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        shift_reg  <= shift_next;
        otone_reg  <= otone_next;
        ostuff_reg <= ostuff_next;
        olast_reg  <= olast_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {7'd0, otone_reg};
    assign m_tuser  = ostuff_reg;
    assign m_tlast  = olast_reg;

endmodule

[sv/hdlc_nrzi_frame_bit_encoder.sv]
// Top level of the HDLC NRZI frame bit encoder (flag, data, FCS commands).
// Instantiates hnfe_sequencer and hnfe_datapath; depends on hnfe_pkg.
//
//  channel | dir | tdata                 | tuser               | tlast
//  s_      | in  | [7:0] data_byte       | [1:0] command       | -
//  m_      | out | [0] line_tone, rest 0 | [0] stuffed         | last bit of item
//
// A command word is taken in a fetch step; no new one is taken until the
// last line bit of the item is sent, one line bit per cycle while the m_
// side keeps up; a reserved command sends none. One microcode step per bit.
// A stalled m_ side holds the step until the output register frees up.
// aresetn is synchronous, active low; the CRC returns to all ones.
module hdlc_nrzi_frame_bit_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] data_byte
    input  logic [1:0] s_tuser,    // [1:0] command
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [0] line_tone, [7:1] zero
    output logic       m_tuser,    // [0] stuffed
    output logic       m_tlast
);
    import hnfe_pkg::*;

    ctrl_word_t ctrl;
    dp_status_t status;

    // Step counter and program
    hnfe_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    // Bit datapath and output register
    hnfe_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .status   (status),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[sv/hnfe_checker.sv]
// Port-level checks for hdlc_nrzi_frame_bit_encoder, bound to the top level.
// Depends on hnfe_pkg for the command codes.
module hnfe_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);
    import hnfe_pkg::*;

    logic prev_tone_reg;

    // Track the line state of the last delivered word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_tone_reg <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            prev_tone_reg <= m_tdata[0];
        end
    end

    // A stuffing zero always toggles the line
    a_stuff_toggles: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tuser) |-> (m_tdata[0] != prev_tone_reg))
        else $error("stuffed word did not toggle the line");

    // A flag command keeps the block busy in the next cycle
    a_flag_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == CMD_FLAG)) |=> !s_tready)
        else $error("input taken again right after a flag command");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output word valid after reset");

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled output word changed");

endmodule

bind hdlc_nrzi_frame_bit_encoder hnfe_checker u_hnfe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[sim/hdlc_nrzi_frame_bit_encoder_tb.sv]
// Self-checking testbench for hdlc_nrzi_frame_bit_encoder: flag, data and FCS commands in,
// one NRZI line bit per output word. Depends on hnfe_pkg and the encoder RTL only.
// A scoreboard class predicts CRC, bit stuffing and line tone, and checks each word in order.
module hdlc_nrzi_frame_bit_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hnfe_pkg::*;

    localparam int IDLE_LIMIT   = 2000;  // cycles with no word moving on either side
    localparam int TARGET_ITEMS = 460;
    localparam int SETTLE       = 30;

    // One predicted line bit period
    typedef struct packed {
        logic tone;
        logic stuffed;
        logic last;
    } line_bit_t;

    class frame_bit_scoreboard;
        logic [15:0] crc;
        logic [2:0]  ones;
        logic        tone;
        line_bit_t   expected_bits[$];
        line_bit_t   held;
        bit          have_held;
        int          errors;

        function new();
            crc       = CRC_INIT;
            ones      = 3'd0;
            tone      = 1'b0;
            have_held = 0;
            errors    = 0;
        endfunction

        // Hold each bit back one step so the final one of an item can be marked last
        function void emit_bit(logic stuffed);
            if (have_held) begin
                expected_bits.push_back(held);
            end
            held      = '{tone: tone, stuffed: stuffed, last: 1'b0};
            have_held = 1;
        endfunction

        // Shift one byte out LSB first; data bits fold into the CRC, flag bits never stuff
        function void shift_byte(logic [7:0] value, cmd_t mode);
            logic b;
            logic fb;
            for (int i = 0; i < 8; i++) begin
                b = value[i];
                if (mode == CMD_FLAG) begin
                    ones = 3'd0;
                end else if (mode == CMD_DATA) begin
                    fb  = crc[0] ^ b;
                    crc = (crc >> 1) ^ (fb ? CRC_POLY : 16'h0000);
                end
                if (!b) begin
                    tone = ~tone;
                    emit_bit(1'b0);
                    ones = 3'd0;
                end else begin
                    emit_bit(1'b0);
                    ones = ones + 3'd1;
                    if (ones >= 3'd5) begin
                        tone = ~tone;
                        emit_bit(1'b1);
                        ones = 3'd0;
                    end
                end
            end
        endfunction

        // Predict the line bits of one accepted command word
        function void note_command(cmd_t cmd, logic [7:0] data);
            logic [15:0] fcs;
            case (cmd)
                CMD_FLAG: begin
                    shift_byte(FLAG_BYTE, CMD_FLAG);
                    crc = CRC_INIT;
                end
                CMD_DATA: begin
                    shift_byte(data, CMD_DATA);
                end
                CMD_FCS: begin
                    fcs = ~crc;
                    shift_byte(fcs[7:0], CMD_FCS);
                    shift_byte(fcs[15:8], CMD_FCS);
                end
                default: begin
                end
            endcase
            if (have_held) begin
                held.last = 1'b1;
                expected_bits.push_back(held);
                have_held = 0;
            end
        endfunction

        task report_mismatch(string msg);
            if (errors < 200) begin
                $display("[%0t] line bit mismatch: %s", $realtime, msg);
            end
            errors++;
        endtask

        // Compare one accepted output word with the oldest prediction
        task check_line_bit(logic [7:0] tdata, logic tuser, logic tlast);
            line_bit_t want;
            if (expected_bits.size() == 0) begin
                report_mismatch($sformatf("unexpected word tdata=%02h tuser=%0b tlast=%0b",
                                          tdata, tuser, tlast));
            end else begin
                want = expected_bits.pop_front();
                if (tdata !== {7'b0, want.tone}) begin
                    report_mismatch($sformatf("tdata got %02h want %02h",
                                              tdata, {7'b0, want.tone}));
                end
                if (tuser !== want.stuffed) begin
                    report_mismatch($sformatf("stuffed got %0b want %0b", tuser, want.stuffed));
                end
                if (tlast !== want.last) begin
                    report_mismatch($sformatf("tlast got %0b want %0b", tlast, want.last));
                end
            end
        endtask
    endclass

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic [1:0] s_tuser  = CMD_FLAG;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    frame_bit_scoreboard sb;
    bit calm = 1'b1;        // no idling on either side while set
    int stall_left = 0;
    int idle_cycles = 0;
    int items_sent = 0;

    hdlc_nrzi_frame_bit_encoder i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Stall the result side at random
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (aresetn && !calm && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            stall_left = pick_gap();
        end else begin
            m_tready <= aresetn;
        end
    end

    // Observe both channels, feed the scoreboard, and watch for a hang
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_command(cmd_t'(s_tuser), s_tdata);
            end
            if (m_tvalid && m_tready) begin
                sb.check_line_bit(m_tdata, m_tuser, m_tlast);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Offer one command word and hold it until taken, then idle a while
    task send_command(cmd_t cmd, logic [7:0] data);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        if (cmd != CMD_RSVD) begin
            items_sent++;
        end
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tuser  <= cmd_t'($urandom_range(0, 3));
            s_tdata  <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Payload bytes leaning toward long runs of ones now and then
    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 5))
            0:       return 8'hFF;
            1:       return 8'($urandom | $urandom);
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Frame: flags, payload, FCS (now and then a second one), closing flag
    task send_frame();
        int n;
        repeat ($urandom_range(1, 2)) send_command(CMD_FLAG, 8'($urandom_range(0, 255)));
        n = $urandom_range(1, 12);
        repeat (n) send_command(CMD_DATA, pick_payload());
        send_command(CMD_FCS, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) begin
            send_command(CMD_FCS, 8'($urandom_range(0, 255)));
        end
        send_command(CMD_FLAG, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, stuffing across bytes, FCS on empty and full frames, reserved
        send_command(CMD_FCS,  8'h00);
        send_command(CMD_FLAG, 8'hFF);
        send_command(CMD_DATA, 8'h00);
        send_command(CMD_DATA, 8'hFF);
        send_command(CMD_DATA, 8'hFF);
        send_command(CMD_DATA, 8'h7E);
        send_command(CMD_DATA, 8'h1F);
        send_command(CMD_DATA, 8'hF8);
        send_command(CMD_RSVD, 8'hFF);
        send_command(CMD_DATA, 8'h55);
        send_command(CMD_DATA, 8'hAA);
        send_command(CMD_FCS,  8'hFF);
        send_command(CMD_FCS,  8'h00);
        send_command(CMD_FLAG, 8'h00);
        send_command(CMD_RSVD, 8'h00);
        send_command(CMD_FCS,  8'h5A);
        send_command(CMD_FLAG, 8'h7E);
        send_command(CMD_DATA, 8'hFF);
        send_command(CMD_DATA, 8'h3F);
        send_command(CMD_FCS,  8'hA5);
        send_command(CMD_FLAG, 8'h81);

        // Random: mostly frames, some loose commands
        while (items_sent < TARGET_ITEMS) begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 8) begin
                send_frame();
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_command(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                end
            end
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        // Let the monitor note the final command before waiting on the queue
        @(posedge aclk);

        // Drain, then let any stray word show up
        while (sb.expected_bits.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[files.f]
sv/hnfe_pkg.sv
sv/hnfe_sequencer.sv
sv/hnfe_datapath.sv
sv/hdlc_nrzi_frame_bit_encoder.sv
sv/hnfe_checker.sv
sim/hdlc_nrzi_frame_bit_encoder_tb.sv
